// File: rtl/udec_pkg.sv
// ---------------------------------------------------------------------------
// udec_pkg: shared types and helpers for the percent decoder
// Character codes, the hex digit lookup and the result word carried
// between the decode stage and the output register.
// ---------------------------------------------------------------------------
package udec_pkg;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // Hex digit lookup: ok flag and nibble value
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // One result word
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       end_of_message;
    } t_result;

    // Anything outside 0-9, A-F, a-f (including bytes 128 and above) is not hex
    function automatic t_hex hex_lookup(input logic [7:0] c);
        t_hex h;
        h = '{ok: 1'b0, value: 4'h0};
        case (c) inside
            [8'h30:8'h39]: h = '{ok: 1'b1, value: c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: h = '{ok: 1'b1, value: 4'(c[2:0] + 3'd1) + 4'd8};
            default:       h = '{ok: 1'b0, value: 4'h0};
        endcase
        return h;
    endfunction

endpackage

// File: rtl/url_percent_decoder_top.sv
// ---------------------------------------------------------------------------
// url_percent_decoder_top: form-urlencoded byte stream decoder
// Input register, decode stage and output register, one word per cycle unless the receiver stalls.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one raw byte and a
//   last-byte flag per word. Output channel (o_out_valid / i_out_ready)
//   carries one result word per input word: a valid flag, the decoded
//   byte (zero when not valid) and an end-of-message flag.
//   A plus gives a space, a percent sign swallows the next two bytes and
//   gives one byte when both are hex digits, anything else passes through.
//   Path: a word accepted from the input channel passes through the input
//   register, then the output register, before it appears on the output.
//   Throughput: one word per cycle unless the receiver stalls, set by the
//   escape phase update between the two registers.
//   Reset (synchronous, active low) empties both registers and returns the
//   escape phase to normal.
//   When the receiver stalls, the output word holds and the input register
//   still fills; o_in_ready drops only once both registers hold a word.
// ---------------------------------------------------------------------------
module url_percent_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_byte_valid,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_message
);

    logic              r_s1_valid;
    logic [7:0]        r_s1_byte;
    logic              r_s1_last;
    logic              r_out_valid;
    udec_pkg::t_result r_out;
    udec_pkg::t_result dec_result;
    logic              dec_idle;
    logic              s1_advance;
    logic              in_accept;

    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte <= i_in_byte;
            r_s1_last <= i_last_byte;
        end
    end

    udec_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_advance),
        .i_byte    (r_s1_byte),
        .i_last    (r_s1_last),
        .o_result  (dec_result),
        .o_idle    (dec_idle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out <= dec_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_valid     = r_out.byte_valid;
    assign o_out_byte       = r_out.out_byte;
    assign o_end_of_message = r_out.end_of_message;

    // A word that advances always lands in the output register
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> o_out_valid)
        else $error("decoded word lost on advance");

    // Full input register that cannot move blocks new words
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance) |-> !o_in_ready)
        else $error("input accepted over a held word");

    // Decoded byte is zero when not valid
    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_out_byte == 8'h00))
        else $error("out byte not cleared on empty result");

    // The end of a message leaves no escape pending
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && r_s1_last) |=> dec_idle)
        else $error("escape state survived end of message");

endmodule

// File: rtl/udec_decode.sv
// ---------------------------------------------------------------------------
// udec_decode: escape phase tracking and byte decode
// Works out the result word for the byte held in the input register and
// moves the escape phase on when that word advances.
// ---------------------------------------------------------------------------
module udec_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output udec_pkg::t_result    o_result,
    output logic                 o_idle
);

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [3:0]      r_high, n_high;
    logic            r_high_ok, n_high_ok;
    udec_pkg::t_hex  hex;

    always_comb begin
        hex       = udec_pkg::hex_lookup(i_byte);
        n_phase   = PH_NORMAL;
        n_high    = r_high;
        n_high_ok = r_high_ok;
        o_result  = '{byte_valid: 1'b0, out_byte: 8'h00, end_of_message: i_last};
        case (r_phase)
            PH_FIRST: begin
                n_high    = hex.value;
                n_high_ok = hex.ok;
                n_phase   = PH_SECOND;
            end
            PH_SECOND: begin
                if (r_high_ok && hex.ok) begin
                    o_result.byte_valid = 1'b1;
                    o_result.out_byte   = {r_high, hex.value};
                end
                n_high    = 4'h0;
                n_high_ok = 1'b0;
            end
            default: begin
                // normal phase, and the unused code falls back to it
                if (i_byte == udec_pkg::CHAR_PLUS) begin
                    o_result.byte_valid = 1'b1;
                    o_result.out_byte   = udec_pkg::CHAR_SPACE;
                end else if (i_byte == udec_pkg::CHAR_PERCENT) begin
                    n_phase = PH_FIRST;
                end else begin
                    o_result.byte_valid = 1'b1;
                    o_result.out_byte   = i_byte;
                end
            end
        endcase
        // drop any pending escape at the end of a message
        if (i_last) begin
            n_phase   = PH_NORMAL;
            n_high    = 4'h0;
            n_high_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_NORMAL;
            r_high    <= 4'h0;
            r_high_ok <= 1'b0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_high    <= n_high;
            r_high_ok <= n_high_ok;
        end
    end

    assign o_idle = (r_phase == PH_NORMAL) && !r_high_ok && (r_high == 4'h0);

endmodule

// File: sim/tb_url_percent_decoder_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_url_percent_decoder_top: self-checking bench for the percent decoder
// Walks a short table of hand-picked words, then a few hundred random
// words shaped as escapes, pluses and raw bytes with random message ends.
// Every accepted input word is run through a local decoder model and
// every output word is compared field by field with the oldest prediction.
// Both channels idle in random bursts, except in the final stretch.
// ---------------------------------------------------------------------------
module tb_url_percent_decoder_top;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } t_phase;

    typedef struct packed {
        logic              in_byte_unused_pad;
        logic [7:0]        in_byte;
        logic              last;
        logic              typed;
        udec_pkg::t_result res;
    } t_row_raw;

    typedef struct packed {
        logic [7:0]        in_byte;
        logic              last;
        logic              typed;
        udec_pkg::t_result res;
    } t_row;

    localparam int                N_DIRECTED = 24;
    localparam int                N_RANDOM   = 400;
    localparam udec_pkg::t_result NO_RES     = '0;

    // Typed results only for raw extremes, the plus and the dropped escapes
    localparam t_row DIRECTED [0:N_DIRECTED-1] = '{
        '{8'h00,                  1'b0, 1'b1, {1'b1, 8'h00, 1'b0}},
        '{8'hFF,                  1'b1, 1'b1, {1'b1, 8'hFF, 1'b1}},
        '{udec_pkg::CHAR_PLUS,    1'b0, 1'b1, {1'b1, udec_pkg::CHAR_SPACE, 1'b0}},
        '{udec_pkg::CHAR_PERCENT, 1'b0, 1'b0, NO_RES},
        '{"f",                    1'b0, 1'b0, NO_RES},
        '{"F",                    1'b0, 1'b0, NO_RES},
        '{udec_pkg::CHAR_PERCENT, 1'b0, 1'b0, NO_RES},
        '{"0",                    1'b0, 1'b0, NO_RES},
        '{"0",                    1'b0, 1'b0, NO_RES},
        '{udec_pkg::CHAR_PERCENT, 1'b0, 1'b1, {1'b0, 8'h00, 1'b0}},
        '{"g",                    1'b0, 1'b1, {1'b0, 8'h00, 1'b0}},
        '{"1",                    1'b0, 1'b1, {1'b0, 8'h00, 1'b0}},
        '{udec_pkg::CHAR_PERCENT, 1'b0, 1'b0, NO_RES},
        '{"9",                    1'b0, 1'b0, NO_RES},
        '{8'hFF,                  1'b0, 1'b0, NO_RES},
        '{udec_pkg::CHAR_PERCENT, 1'b0, 1'b0, NO_RES},
        '{8'hC1,                  1'b0, 1'b0, NO_RES},
        '{"1",                    1'b0, 1'b0, NO_RES},
        '{udec_pkg::CHAR_PERCENT, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1}},
        '{udec_pkg::CHAR_PERCENT, 1'b0, 1'b0, NO_RES},
        '{"a",                    1'b1, 1'b0, NO_RES},
        '{udec_pkg::CHAR_PERCENT, 1'b0, 1'b0, NO_RES},
        '{"B",                    1'b0, 1'b0, NO_RES},
        '{"c",                    1'b1, 1'b0, NO_RES}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_byte_valid;
    logic [7:0] o_out_byte;
    logic       o_end_of_message;

    // Side information travelling with the word on the input channel
    logic              row_typed = 1'b0;
    udec_pkg::t_result row_res = '0;

    t_phase     esc_phase = PH_NORMAL;
    logic [3:0] esc_high = 4'h0;
    logic       esc_high_ok = 1'b0;

    udec_pkg::t_result pending_results[$];
    int                fail_count = 0;
    int                words_sent = 0;
    logic              steady = 1'b0;

    url_percent_decoder_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_byte        (i_in_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_valid     (o_byte_valid),
        .o_out_byte       (o_out_byte),
        .o_end_of_message (o_end_of_message)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic udec_pkg::t_hex hex_digit(input logic [7:0] c);
        udec_pkg::t_hex h;
        h = '0;
        if (c >= "0" && c <= "9") begin
            h.ok = 1'b1;
            h.value = 4'(c - "0");
        end else if (c >= "A" && c <= "F") begin
            h.ok = 1'b1;
            h.value = 4'(c - "A" + 8'd10);
        end else if (c >= "a" && c <= "f") begin
            h.ok = 1'b1;
            h.value = 4'(c - "a" + 8'd10);
        end
        return h;
    endfunction

    // Advance the local escape state by one byte and give its result word
    function automatic udec_pkg::t_result decode_step(input logic [7:0] c,
                                                      input logic last);
        udec_pkg::t_result r;
        udec_pkg::t_hex    h;
        r = '0;
        h = hex_digit(c);
        case (esc_phase)
            PH_FIRST: begin
                esc_high = h.ok ? h.value : 4'h0;
                esc_high_ok = h.ok;
                esc_phase = PH_SECOND;
            end
            PH_SECOND: begin
                if (esc_high_ok && h.ok) begin
                    r.byte_valid = 1'b1;
                    r.out_byte = {esc_high, h.value};
                end
                esc_phase = PH_NORMAL;
                esc_high = 4'h0;
                esc_high_ok = 1'b0;
            end
            default: begin
                esc_phase = PH_NORMAL;
                if (c == udec_pkg::CHAR_PLUS) begin
                    r.byte_valid = 1'b1;
                    r.out_byte = udec_pkg::CHAR_SPACE;
                end else if (c == udec_pkg::CHAR_PERCENT) begin
                    esc_phase = PH_FIRST;
                end else begin
                    r.byte_valid = 1'b1;
                    r.out_byte = c;
                end
            end
        endcase
        // a message end always drops any open escape
        if (last) begin
            esc_phase = PH_NORMAL;
            esc_high = 4'h0;
            esc_high_ok = 1'b0;
        end
        r.end_of_message = last;
        return r;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int d;
        d = $urandom_range(0, 21);
        if (d < 10)
            return 8'("0" + d);
        else if (d < 16)
            return 8'("A" + d - 10);
        else
            return 8'("a" + d - 16);
    endfunction

    // Present one word at the falling edge and hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic last,
                             input logic typed, input udec_pkg::t_result res);
        logic taken;
        if (!steady && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte = b;
        i_last_byte = last;
        row_typed = typed;
        row_res = res;
        do begin
            @(posedge i_clk);
            taken = i_in_valid && o_in_ready;
            @(negedge i_clk);
        end while (!taken);
        words_sent++;
    endtask

    task automatic send_random_byte(input logic [7:0] b);
        send_word(b, $urandom_range(0, 9) == 0, 1'b0, NO_RES);
    endtask

    // Receiver: stall in random bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (!steady && i_rst_n && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        udec_pkg::t_result got;
        udec_pkg::t_result want;
        if (!i_rst_n) begin
            esc_phase = PH_NORMAL;
            esc_high = 4'h0;
            esc_high_ok = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                want = decode_step(i_in_byte, i_last_byte);
                pending_results = {pending_results, (row_typed ? row_res : want)};
            end
            if (o_out_valid && i_out_ready) begin
                got = {o_byte_valid, o_out_byte, o_end_of_message};
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.byte_valid !== want.byte_valid) begin
                        $display("%0t: byte_valid mismatch, expected %0d, actual %0d",
                                 $time, want.byte_valid, got.byte_valid);
                        fail_count++;
                    end
                    if (got.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want.out_byte, got.out_byte);
                        fail_count++;
                    end
                    if (got.end_of_message !== want.end_of_message) begin
                        $display("%0t: end_of_message mismatch, expected %0d, actual %0d",
                                 $time, want.end_of_message, got.end_of_message);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        int kind;
        int guard;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++)
            send_word(DIRECTED[k].in_byte, DIRECTED[k].last,
                      DIRECTED[k].typed, DIRECTED[k].res);

        while (words_sent < N_DIRECTED + N_RANDOM) begin
            // drop idling for the final stretch
            if (words_sent >= N_DIRECTED + N_RANDOM - 70)
                steady = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                send_random_byte(8'($urandom_range(0, 255)));
            end else if (kind < 55) begin
                send_random_byte(udec_pkg::CHAR_PLUS);
            end else if (kind < 85) begin
                send_random_byte(udec_pkg::CHAR_PERCENT);
                send_random_byte(rand_hex_char());
                send_random_byte(rand_hex_char());
            end else begin
                send_random_byte(udec_pkg::CHAR_PERCENT);
                send_random_byte(8'($urandom_range(0, 255)));
                send_random_byte(8'($urandom_range(0, 255)));
            end
        end
        i_in_valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        guard = 10;
        repeat (guard) @(posedge i_clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: url_percent_decoder_top.f
rtl/udec_pkg.sv
rtl/udec_decode.sv
rtl/url_percent_decoder_top.sv
sim/tb_url_percent_decoder_top.sv
